[rtl/adf_pkg.sv]
// Shared constants, job types and helper functions of the ASCII decimal-to-fixed converter.
package adf_pkg;

  // Default number of fraction bits of the fixed-point result
  localparam int FRAC_BITS_DEF = 32;
  // Significant decimal digits kept in the significand
  localparam int MAX_DIGITS    = 18;
  // Largest net power of ten that is still scaled
  localparam int POW_RANGE     = 40;

  // Significand width holds any value below 10^18
  localparam int SIG_W         = 60;
  // Scale count width, enough for POW_RANGE up to 64
  localparam int QW            = 7;
  // Exponent digits saturate here
  localparam int EXP_W         = 10;
  localparam logic [EXP_W-1:0] EXP_MAX = 10'd1023;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EXP   = 8'h65;

  // Elaboration-time power of ten, n no larger than 19
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < 19; i++) begin
      if (i < n) begin
        r = (r << 3) + (r << 1);
      end
    end
    return r;
  endfunction

  // Once the significand reaches this, further digits are not significant
  localparam logic [SIG_W-1:0] SIG_FULL = SIG_W'(pow10(MAX_DIGITS - 1));

  // Class of a finished number, decided in the front end
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_SAT,
    CLS_POS,
    CLS_NEG
  } adf_cls_t;

  // One conversion job handed from the parser to the scaling unit
  typedef struct packed {
    adf_cls_t         cls;
    logic             neg;
    logic [QW-1:0]    q;
    logic [SIG_W-1:0] sig;
  } adf_job_t;

endpackage

[rtl/adf_front.sv]
// Character parser: builds significand, decimal shift and exponent, classifies on the last word.
module adf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        chr,
  input  logic              last,
  output logic              push,
  output adf_pkg::adf_job_t job
);

  localparam int SIG_W = adf_pkg::SIG_W;
  localparam int QW    = adf_pkg::QW;
  localparam int EXP_W = adf_pkg::EXP_W;
  localparam logic signed [11:0] PR_S = 12'(adf_pkg::POW_RANGE);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_INT,
    PH_FRAC,
    PH_ESIGN,
    PH_EXP,
    PH_DONE
  } phase_t;

  phase_t             ph_r, ph_nxt;
  logic [SIG_W-1:0]   sig_r, sig_nxt;
  logic signed [7:0]  sh_r, sh_nxt;
  logic               mneg_r, mneg_nxt;
  logic [EXP_W-1:0]   ev_r, ev_nxt;
  logic               eneg_r, eneg_nxt;

  logic               is_dig, is_sign, int_arm, sig_full;
  logic [3:0]         dig;
  logic [SIG_W-1:0]   sig_x10d;
  logic [13:0]        ev_x10d;
  logic signed [11:0] e_s, p_s;

  assign is_dig   = (chr >= adf_pkg::CH_ZERO) && (chr <= adf_pkg::CH_NINE);
  assign is_sign  = (chr == adf_pkg::CH_MINUS) || (chr == adf_pkg::CH_PLUS);
  assign dig      = 4'(chr - adf_pkg::CH_ZERO);
  assign sig_full = sig_r >= adf_pkg::SIG_FULL;
  assign sig_x10d = SIG_W'((sig_r << 3) + (sig_r << 1)) + SIG_W'(dig);
  assign ev_x10d  = ({4'b0, ev_r} << 3) + ({4'b0, ev_r} << 1) + 14'(dig);

  always_comb begin
    ph_nxt   = ph_r;
    sig_nxt  = sig_r;
    sh_nxt   = sh_r;
    mneg_nxt = mneg_r;
    ev_nxt   = ev_r;
    eneg_nxt = eneg_r;
    int_arm  = 1'b0;

    unique case (ph_r)
      PH_SPACE: begin
        if (chr == adf_pkg::CH_SPACE) begin
          ph_nxt = PH_SPACE;
        end else if (is_sign) begin
          mneg_nxt = (chr == adf_pkg::CH_MINUS);
          ph_nxt   = PH_INT;
        end else begin
          int_arm = 1'b1;
        end
      end
      PH_INT: begin
        int_arm = 1'b1;
      end
      PH_FRAC: begin
        if (is_dig) begin
          if (!sig_full) begin
            if (sh_r != 8'sh7F) begin
              sh_nxt = sh_r + 8'sd1;
            end
            sig_nxt = sig_x10d;
          end
        end else if (chr == adf_pkg::CH_EXP) begin
          ph_nxt = PH_ESIGN;
        end else begin
          ph_nxt = PH_DONE;
        end
      end
      PH_ESIGN: begin
        if (is_sign) begin
          eneg_nxt = (chr == adf_pkg::CH_MINUS);
          ph_nxt   = PH_EXP;
        end else if (is_dig) begin
          ev_nxt = (ev_x10d > 14'(adf_pkg::EXP_MAX)) ? adf_pkg::EXP_MAX : ev_x10d[EXP_W-1:0];
          ph_nxt = PH_EXP;
        end else begin
          ph_nxt = PH_DONE;
        end
      end
      PH_EXP: begin
        if (is_dig) begin
          ev_nxt = (ev_x10d > 14'(adf_pkg::EXP_MAX)) ? adf_pkg::EXP_MAX : ev_x10d[EXP_W-1:0];
        end else begin
          ph_nxt = PH_DONE;
        end
      end
      default: begin
        ph_nxt = PH_DONE;
      end
    endcase

    // Integer part, also reached from the leading-space phase
    if (int_arm) begin
      if (is_dig) begin
        ph_nxt = PH_INT;
        if (!(sig_r == '0 && dig == 4'd0)) begin
          if (sig_full) begin
            if (sh_r != 8'sh80) begin
              sh_nxt = sh_r - 8'sd1;
            end
          end else begin
            sig_nxt = sig_x10d;
          end
        end
      end else if (chr == adf_pkg::CH_DOT) begin
        ph_nxt = PH_FRAC;
      end else if (chr == adf_pkg::CH_EXP) begin
        ph_nxt = PH_ESIGN;
      end else begin
        ph_nxt = PH_DONE;
      end
    end
  end

  // Net power of ten from the updated state
  always_comb begin
    e_s = eneg_nxt ? -$signed({2'b00, ev_nxt}) : $signed({2'b00, ev_nxt});
    p_s = e_s - $signed({{4{sh_nxt[7]}}, sh_nxt});

    job.neg = mneg_nxt;
    job.sig = sig_nxt;
    job.q   = '0;
    if (sig_nxt == '0 || p_s < -PR_S) begin
      job.cls = adf_pkg::CLS_ZERO;
    end else if (p_s > PR_S) begin
      job.cls = adf_pkg::CLS_SAT;
    end else if (p_s >= 12'sd0) begin
      job.cls = adf_pkg::CLS_POS;
      job.q   = QW'(p_s);
    end else begin
      job.cls = adf_pkg::CLS_NEG;
      job.q   = QW'(-p_s);
    end
  end

  assign push = take && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_SPACE;
      sig_r  <= '0;
      sh_r   <= '0;
      mneg_r <= 1'b0;
      ev_r   <= '0;
      eneg_r <= 1'b0;
    end else if (take) begin
      if (last) begin
        ph_r   <= PH_SPACE;
        sig_r  <= '0;
        sh_r   <= '0;
        mneg_r <= 1'b0;
        ev_r   <= '0;
        eneg_r <= 1'b0;
      end else begin
        ph_r   <= ph_nxt;
        sig_r  <= sig_nxt;
        sh_r   <= sh_nxt;
        mneg_r <= mneg_nxt;
        ev_r   <= ev_nxt;
        eneg_r <= eneg_nxt;
      end
    end
  end

endmodule

[rtl/adf_queue.sv]
// Two-entry job queue between parser and scaling unit.
module adf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  adf_pkg::adf_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output adf_pkg::adf_job_t head
);

  adf_pkg::adf_job_t entry_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

[rtl/adf_back.sv]
// Scaling unit: shift-add power of ten, restoring division, saturation and output register.
module adf_back #(
  parameter int FRAC_BITS = adf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  adf_pkg::adf_job_t job,
  output logic              job_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic              out_tuser
);

  localparam int NW = adf_pkg::SIG_W + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam int QW = adf_pkg::QW;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POW,
    ST_DIV,
    ST_CHK,
    ST_FIN
  } state_t;

  state_t         state_r, state_nxt;
  logic           neg_r, neg_nxt;
  logic           ovf_r, ovf_nxt;
  logic           div_r, div_nxt;
  logic [QW-1:0]  pcnt_r, pcnt_nxt;
  logic [CW-1:0]  bcnt_r, bcnt_nxt;
  logic [NW-1:0]  acc_r, acc_nxt;
  logic [NW-1:0]  den_r, den_nxt;
  logic [NW-1:0]  rem_r, rem_nxt;
  logic [63:0]    mag_r, mag_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  logic [63:0]    out_tdata_r, out_tdata_nxt;
  logic           out_tuser_r, out_tuser_nxt;

  logic [63:0]    lim, limhi;
  logic [NW-1:0]  acc_x10, acc_shl;
  logic [NW+3:0]  den_x10;
  logic [NW:0]    trial, diff;
  logic           ge, acc_gt_limhi, q_gt_lim, out_free;

  assign lim          = neg_r ? NEG_MAX : POS_MAX;
  assign limhi        = lim >> FRAC_BITS;
  assign acc_gt_limhi = acc_r > {{(NW-64){1'b0}}, limhi};
  assign acc_x10      = (acc_r << 3) + (acc_r << 1);
  assign acc_shl      = acc_r << FRAC_BITS;
  assign den_x10      = ({4'b0, den_r} << 3) + ({4'b0, den_r} << 1);
  assign trial        = {rem_r, acc_r[NW-1]};
  assign ge           = trial >= {1'b0, den_r};
  assign diff         = trial - {1'b0, den_r};
  assign q_gt_lim     = (|acc_r[NW-1:64]) || (acc_r[63:0] > lim);
  assign out_free     = !out_tvalid_r || out_tready;
  assign job_pop      = (state_r == ST_IDLE) && job_valid;

  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    ovf_nxt        = ovf_r;
    div_nxt        = div_r;
    pcnt_nxt       = pcnt_r;
    bcnt_nxt       = bcnt_r;
    acc_nxt        = acc_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    mag_nxt        = mag_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          neg_nxt = job.neg;
          ovf_nxt = 1'b0;
          mag_nxt = '0;
          unique case (job.cls)
            adf_pkg::CLS_ZERO: begin
              state_nxt = ST_FIN;
            end
            adf_pkg::CLS_SAT: begin
              ovf_nxt   = 1'b1;
              state_nxt = ST_FIN;
            end
            adf_pkg::CLS_POS: begin
              acc_nxt   = {{FRAC_BITS{1'b0}}, job.sig};
              pcnt_nxt  = job.q;
              div_nxt   = 1'b0;
              state_nxt = ST_MUL;
            end
            default: begin
              acc_nxt   = {job.sig, {FRAC_BITS{1'b0}}};
              den_nxt   = NW'(10);
              pcnt_nxt  = job.q - QW'(1);
              div_nxt   = 1'b1;
              state_nxt = ST_POW;
            end
          endcase
        end
      end
      ST_MUL: begin
        // Stop early once past the limit: further steps only grow
        if (pcnt_r == '0) begin
          state_nxt = ST_CHK;
        end else if (acc_gt_limhi) begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_CHK;
        end else begin
          acc_nxt  = acc_x10;
          pcnt_nxt = pcnt_r - QW'(1);
        end
      end
      ST_POW: begin
        if (pcnt_r == '0) begin
          rem_nxt   = '0;
          bcnt_nxt  = CW'(NW - 1);
          state_nxt = ST_DIV;
        end else if (|den_x10[NW+3:NW]) begin
          // Divisor beyond any dividend: quotient is zero
          mag_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          den_nxt  = den_x10[NW-1:0];
          pcnt_nxt = pcnt_r - QW'(1);
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[NW-1:0] : trial[NW-1:0];
        acc_nxt = {acc_r[NW-2:0], ge};
        if (bcnt_r == '0) begin
          state_nxt = ST_CHK;
        end else begin
          bcnt_nxt = bcnt_r - CW'(1);
        end
      end
      ST_CHK: begin
        if (div_r) begin
          ovf_nxt = q_gt_lim;
          mag_nxt = acc_r[63:0];
        end else begin
          ovf_nxt = ovf_r || acc_gt_limhi;
          mag_nxt = acc_shl[63:0];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = ovf_r;
          if (ovf_r) begin
            out_tdata_nxt = neg_r ? NEG_MAX : POS_MAX;
          end else begin
            out_tdata_nxt = neg_r ? (64'd0 - mag_r) : mag_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    neg_r       <= neg_nxt;
    ovf_r       <= ovf_nxt;
    div_r       <= div_nxt;
    pcnt_r      <= pcnt_nxt;
    bcnt_r      <= bcnt_nxt;
    acc_r       <= acc_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    mag_r       <= mag_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[rtl/ascii_decimal_to_fixed.sv]
// Top level of the streaming ASCII decimal to signed fixed-point converter.
// Input: one character word per cycle while the two-entry job queue has room.
// Zero and clamped results skip scaling; positive powers of ten are applied with one
// multiply-by-ten per cycle, and negative ones by a restoring divider, one bit a cycle.
// Reset (rst_n low, synchronous) returns parser, queue and output to empty.
module ascii_decimal_to_fixed #(
  parameter int FRAC_BITS = adf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value, signed fixed point
  output logic        out_tuser   // [0] saturated
);

  logic              take;
  logic              push, full, empty, pop;
  adf_pkg::adf_job_t push_job, head_job;

  // Hold off characters only when the queue cannot take another job
  assign in_tready = !full;
  assign take      = in_tvalid && in_tready;

  // Front end: parse each word, classify the number on the last one
  adf_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .chr   (in_tdata),
    .last  (in_tlast),
    .push  (push),
    .job   (push_job)
  );

  // Decouple the parser, one word per cycle while the queue has room, from the multi-cycle scaler
  adf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head_job)
  );

  // Back end: scale by the power of ten, clamp, and register the result word
  adf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (!empty),
    .job        (head_job),
    .job_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/adf_checker.sv]
// Port-level checks of the converter, bound to the top level.
module adf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A clamped result sits at one of the two end codes
  a_sat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata == 64'h7FFF_FFFF_FFFF_FFFF) || (out_tdata == 64'h8000_0000_0000_0000))
    else $error("saturated flag without an end code");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Reset empties the job queue, so characters are taken at once
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind ascii_decimal_to_fixed adf_checker u_adf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
